// ===== hw/rtl/direct_mapped_symbol_cache_assert.svh =====
// Assertion macros shared by the symbol cache modules.
`ifndef DIRECT_MAPPED_SYMBOL_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_SYMBOL_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

`define DMSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define DMSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DMSC_ASSERT(lbl, prop, msg)

`define DMSC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/dmsc_pkg.sv =====
// Package with op codes, command classes and the queued command type.
`timescale 1ns / 1ps

package dmsc_pkg;

  localparam int HASH_W      = 6;
  localparam int HANDLE_W    = 32;
  localparam int MODE_W      = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ENTER  = 2'd1,
    OP_INVAL  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_LOOKUP,
    KIND_ENTER,
    KIND_SWEEP,
    KIND_NOP
  } kind_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK,
    BK_SWEEP,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] import_id;
    logic [MODE_W-1:0]   mode_flags;
    logic [HANDLE_W-1:0] module_id;
    logic [HANDLE_W-1:0] export_id;
  } cmd_t;

endpackage

// ===== hw/rtl/dmsc_front.sv =====
// Front end: accept request beats, classify the op, form the slot index.
`timescale 1ns / 1ps

module dmsc_front #(
  parameter int SLOTS = 64,
  parameter int IDX_W = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    op,
  input  logic [dmsc_pkg::HASH_W-1:0]   slot_hash,
  input  logic [dmsc_pkg::HANDLE_W-1:0] import_id,
  input  logic [dmsc_pkg::MODE_W-1:0]   mode_flags,
  input  logic [dmsc_pkg::HANDLE_W-1:0] module_id,
  input  logic [dmsc_pkg::HANDLE_W-1:0] export_id,
  output logic                          cmd_valid,
  output dmsc_pkg::cmd_t                cmd,
  output logic [IDX_W-1:0]              cmd_idx,
  input  logic                          q_full
);
  import dmsc_pkg::*;

  localparam int MW = (IDX_W > HASH_W) ? IDX_W : HASH_W;

  logic          accept;
  logic          push;
  kind_t         kind_in;
  logic [MW-1:0] masked;

  assign push      = cmd_valid && !q_full;
  assign req_stall = cmd_valid && q_full;
  assign accept    = req_valid && !req_stall;
  assign masked    = MW'(slot_hash) & MW'(SLOTS - 1);

  always_comb begin
    case (op)
      OP_LOOKUP: kind_in = KIND_LOOKUP;
      OP_ENTER:  kind_in = KIND_ENTER;
      OP_INVAL:  kind_in = KIND_SWEEP;
      default:   kind_in = KIND_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind       <= kind_in;
      cmd.import_id  <= import_id;
      cmd.mode_flags <= mode_flags;
      cmd.module_id  <= module_id;
      cmd.export_id  <= export_id;
      cmd_idx        <= masked[IDX_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/dmsc_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`include "direct_mapped_symbol_cache_assert.svh"

module dmsc_queue #(
  parameter int W = 120
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] q_data,
  output logic         empty
);
  import dmsc_pkg::*;

  logic [W-1:0]      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `DMSC_ASSERT(a_no_pop_empty, pop |-> !empty, "queue popped while empty")
  `DMSC_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

// ===== hw/rtl/dmsc_back.sv =====
// Back end: slot memories, lookup/enter/sweep sequencer and result register.
`timescale 1ns / 1ps
`include "direct_mapped_symbol_cache_assert.svh"

module dmsc_back #(
  parameter int SLOTS = 64,
  parameter int IDX_W = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dmsc_pkg::cmd_t                q_cmd,
  input  logic [IDX_W-1:0]              q_idx,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          hit,
  output logic [dmsc_pkg::HANDLE_W-1:0] found_module,
  output logic [dmsc_pkg::HANDLE_W-1:0] found_export
);
  import dmsc_pkg::*;

  logic [HANDLE_W-1:0] tag_mem    [SLOTS];
  logic [MODE_W-1:0]   mode_mem   [SLOTS];
  logic [HANDLE_W-1:0] module_mem [SLOTS];
  logic [HANDLE_W-1:0] export_mem [SLOTS];

  logic [HANDLE_W-1:0] tag_rd;
  logic [MODE_W-1:0]   mode_rd;
  logic [HANDLE_W-1:0] module_rd;
  logic [HANDLE_W-1:0] export_rd;

  back_state_t         state;
  back_state_t         state_next;
  logic [IDX_W-1:0]    ptr;
  logic [HANDLE_W-1:0] look_imp;
  logic [MODE_W-1:0]   look_mode;
  logic [HANDLE_W-1:0] sweep_mod;
  logic                chk_valid;
  logic [IDX_W-1:0]    chk_idx;

  logic                res_free;
  logic                rsp_take;
  logic                ptr_last;
  logic                chk_clear;
  logic                tag_we;
  logic [IDX_W-1:0]    tag_wa;
  logic [HANDLE_W-1:0] tag_wd;
  logic                ent_we;
  logic [IDX_W-1:0]    rd_addr;
  logic                res_load;
  logic                hit_next;
  logic [HANDLE_W-1:0] found_module_next;
  logic [HANDLE_W-1:0] found_export_next;
  logic                look_hit;

  assign rsp_take  = rsp_valid && !rsp_stall;
  assign res_free  = !rsp_valid || !rsp_stall;
  assign ptr_last  = (ptr == IDX_W'(SLOTS - 1));
  assign chk_clear = chk_valid && ((sweep_mod == '0) || (module_rd == sweep_mod));
  assign look_hit  = (look_imp != '0) && (tag_rd == look_imp) && (mode_rd == look_mode);

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (ptr_last) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_pop && q_cmd.kind == KIND_LOOKUP) state_next = BK_LOOK;
        if (q_pop && q_cmd.kind == KIND_SWEEP)  state_next = BK_SWEEP;
      end
      BK_LOOK:  state_next = BK_IDLE;
      BK_SWEEP: begin
        if (ptr_last) state_next = BK_DRAIN;
      end
      BK_DRAIN: state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop             = 1'b0;
    tag_we            = 1'b0;
    tag_wa            = q_idx;
    tag_wd            = q_cmd.import_id;
    ent_we            = 1'b0;
    rd_addr           = q_idx;
    res_load          = 1'b0;
    hit_next          = 1'b0;
    found_module_next = '0;
    found_export_next = '0;
    case (state)
      BK_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = ptr;
        tag_wd = '0;
      end
      BK_IDLE: begin
        q_pop = !q_empty && res_free;
        if (q_pop) begin
          case (q_cmd.kind)
            KIND_ENTER: begin
              tag_we   = 1'b1;
              ent_we   = 1'b1;
              res_load = 1'b1;
            end
            KIND_NOP: res_load = 1'b1;
            default:  res_load = 1'b0;
          endcase
        end
      end
      BK_LOOK: begin
        res_load          = 1'b1;
        hit_next          = look_hit;
        found_module_next = look_hit ? module_rd : '0;
        found_export_next = look_hit ? export_rd : '0;
      end
      BK_SWEEP: begin
        rd_addr = ptr;
        tag_we  = chk_clear;
        tag_wa  = chk_idx;
        tag_wd  = '0;
      end
      BK_DRAIN: begin
        res_load = 1'b1;
        tag_we   = chk_clear;
        tag_wa   = chk_idx;
        tag_wd   = '0;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      ptr       <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= (state == BK_SWEEP);
      if (state == BK_CLEAR || state == BK_SWEEP) begin
        ptr <= ptr_last ? '0 : ptr + 1'b1;
      end
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= ptr;
    if (q_pop) begin
      look_imp  <= q_cmd.import_id;
      look_mode <= q_cmd.mode_flags;
      sweep_mod <= q_cmd.module_id;
    end
    if (res_load) begin
      hit          <= hit_next;
      found_module <= found_module_next;
      found_export <= found_export_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) mode_mem[q_idx] <= q_cmd.mode_flags;
    mode_rd <= mode_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) module_mem[q_idx] <= q_cmd.module_id;
    module_rd <= module_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) export_mem[q_idx] <= q_cmd.export_id;
    export_rd <= export_mem[rd_addr];
  end

  `DMSC_ASSERT(a_look_from_pop, (state == BK_LOOK) |-> ($past(q_pop) && $past(state) == BK_IDLE), "lookup stage without a popped lookup")
  `DMSC_ASSERT(a_hit_only_lookup, (res_load && hit_next) |-> (state == BK_LOOK), "hit loaded outside lookup")
  `DMSC_ASSERT(a_pop_needs_room, q_pop |-> (!rsp_valid || !rsp_stall), "command popped while result register is held")

endmodule

// ===== hw/rtl/direct_mapped_symbol_cache.sv =====
// Top level of the direct-mapped symbol cache.
`timescale 1ns / 1ps

// Direct-mapped cache of resolved symbols with SLOTS entries, indexed by
// slot_hash masked to the table size. Every request beat gives one response
// beat. Requests pass a registered front end and a two-entry command queue,
// so up to three beats are taken while the back end is busy. In the back
// end a lookup does a registered read of the slot memories, then the tag
// and mode compare; enter and the unused op load the result when popped;
// invalidate sweeps one slot per cycle through the module memory, with one
// read and at most one tag write a cycle. After reset the back end clears
// every tag memory slot before it serves the first command. A command
// leaves the queue only when the response register is free or being taken.
module direct_mapped_symbol_cache #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    op,
  input  logic [dmsc_pkg::HASH_W-1:0]   slot_hash,
  input  logic [dmsc_pkg::HANDLE_W-1:0] import_id,
  input  logic [dmsc_pkg::MODE_W-1:0]   mode_flags,
  input  logic [dmsc_pkg::HANDLE_W-1:0] module_id,
  input  logic [dmsc_pkg::HANDLE_W-1:0] export_id,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          hit,
  output logic [dmsc_pkg::HANDLE_W-1:0] found_module,
  output logic [dmsc_pkg::HANDLE_W-1:0] found_export
);
  import dmsc_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int QW    = $bits(cmd_t) + IDX_W;

  logic             cmd_valid;
  cmd_t             cmd;
  logic [IDX_W-1:0] cmd_idx;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [QW-1:0]    q_data;
  cmd_t             q_cmd;
  logic [IDX_W-1:0] q_idx;

  assign q_cmd = q_data[QW-1:IDX_W];
  assign q_idx = q_data[IDX_W-1:0];

  dmsc_front #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .slot_hash (slot_hash),
    .import_id (import_id),
    .mode_flags(mode_flags),
    .module_id (module_id),
    .export_id (export_id),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_idx   (cmd_idx),
    .q_full    (q_full)
  );

  dmsc_queue #(
    .W(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .push_data({cmd, cmd_idx}),
    .full     (q_full),
    .pop      (q_pop),
    .q_data   (q_data),
    .empty    (q_empty)
  );

  dmsc_back #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_cmd       (q_cmd),
    .q_idx       (q_idx),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .found_module(found_module),
    .found_export(found_export)
  );

endmodule

// ===== tb/direct_mapped_symbol_cache_tb.sv =====
// Self-checking testbench for the direct-mapped symbol cache: directed table, then random traffic.
`timescale 1ns / 1ps

module direct_mapped_symbol_cache_tb;
  import dmsc_pkg::*;

  localparam int          SLOTS     = 64;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int          RAND_BEATS = 1500;

  typedef struct packed {
    logic [1:0]          op;
    logic [HASH_W-1:0]   hash;
    logic [HANDLE_W-1:0] imp_h;
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] mod_h;
    logic [HANDLE_W-1:0] exp_h;
  } symreq_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_mod;
    logic [HANDLE_W-1:0] found_exp;
  } answer_t;

  typedef struct packed {
    symreq_t rq;
    logic    typed;
    answer_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] op = '0;
  logic [HASH_W-1:0] slot_hash = '0;
  logic [HANDLE_W-1:0] import_id = '0;
  logic [MODE_W-1:0] mode_flags = '0;
  logic [HANDLE_W-1:0] module_id = '0;
  logic [HANDLE_W-1:0] export_id = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic hit;
  logic [HANDLE_W-1:0] found_module;
  logic [HANDLE_W-1:0] found_export;

  direct_mapped_symbol_cache #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .slot_hash(slot_hash), .import_id(import_id),
    .mode_flags(mode_flags), .module_id(module_id), .export_id(export_id),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .hit(hit), .found_module(found_module), .found_export(found_export)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [HANDLE_W-1:0] tag_mirror [SLOTS];
  logic [MODE_W-1:0]   mode_mirror [SLOTS];
  logic [HANDLE_W-1:0] mod_mirror [SLOTS];
  logic [HANDLE_W-1:0] exp_mirror [SLOTS];

  answer_t answer_q[$];
  int fail_count = 0;
  int n_lookup = 0, n_hit = 0, n_enter = 0, n_sweep = 0, n_unused = 0, n_beats = 0;
  int rsp_seen = 0;
  logic [HANDLE_W-1:0] mod_pool [4];
  logic [HANDLE_W-1:0] imp_pool [8];

  dir_row_t dir_rows [23] = '{
    '{'{OP_LOOKUP, 6'd0, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'h0},
      1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_ENTER, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'h0},
      1'b1, '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{'{OP_LOOKUP, 6'd63, 32'hFFFF_FFFF, 16'hFFFE, 32'h0, 32'h0},
      1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd63, 32'hFFFF_FFFE, 16'hFFFF, 32'h0, 32'h0},
      1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_ENTER, 6'd0, 32'h1, 16'h0, 32'h1, 32'h0}, 1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd0, 32'h1, 16'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, 32'h1, 32'h0}},
    '{'{OP_ENTER, 6'd5, 32'h0, 16'h7, 32'h3, 32'h9}, 1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd5, 32'h0, 16'h7, 32'h0, 32'h0}, 1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_UNUSED, 6'd7, 32'h77, 16'h7, 32'h7, 32'h7}, 1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd7, 32'h77, 16'h7, 32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_ENTER, 6'd10, 32'hA5A5_A5A5, 16'h5A5A, 32'h0000_1234, 32'hCAFE_F00D},
      1'b0, '0},
    '{'{OP_ENTER, 6'd42, 32'h5A5A_5A5A, 16'hA5A5, 32'h1, 32'h0BAD_BEEF}, 1'b0, '0},
    '{'{OP_INVAL, 6'd0, 32'h0, 16'h0, 32'h1, 32'h0}, 1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd0, 32'h1, 16'h0, 32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_LOOKUP, 6'd42, 32'h5A5A_5A5A, 16'hA5A5, 32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_LOOKUP, 6'd10, 32'hA5A5_A5A5, 16'h5A5A, 32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_INVAL, 6'd0, 32'h0, 16'h0, 32'h8000_0000, 32'h0}, 1'b0, '0},
    '{'{OP_LOOKUP, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_INVAL, 6'd0, 32'h0, 16'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, 32'h0, 32'h0}},
    '{'{OP_LOOKUP, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_LOOKUP, 6'd10, 32'hA5A5_A5A5, 16'h5A5A, 32'h0, 32'h0}, 1'b0, '0}
  };

  function automatic answer_t cache_step(symreq_t r);
    answer_t a;
    int idx;
    a = '0;
    idx = (int'(r.hash) & (SLOTS - 1)) % SLOTS;
    case (r.op)
      OP_LOOKUP: begin
        n_lookup++;
        if (r.imp_h != '0 && tag_mirror[idx] == r.imp_h && mode_mirror[idx] == r.mode) begin
          a.hit = 1'b1;
          a.found_mod = mod_mirror[idx];
          a.found_exp = exp_mirror[idx];
          n_hit++;
        end
      end
      OP_ENTER: begin
        n_enter++;
        tag_mirror[idx] = r.imp_h;
        mode_mirror[idx] = r.mode;
        mod_mirror[idx] = r.mod_h;
        exp_mirror[idx] = r.exp_h;
      end
      OP_INVAL: begin
        n_sweep++;
        for (int i = 0; i < SLOTS; i++) begin
          if (r.mod_h == '0 || mod_mirror[i] == r.mod_h) tag_mirror[i] = '0;
        end
      end
      default: n_unused++;
    endcase
    return a;
  endfunction

  function automatic symreq_t pick_request();
    symreq_t r;
    int sel;
    int idx;
    r.op = 2'($urandom_range(0, 3));
    r.hash = HASH_W'($urandom);
    r.imp_h = $urandom;
    r.mode = MODE_W'($urandom);
    r.mod_h = $urandom;
    r.exp_h = $urandom;
    if ($urandom_range(0, 99) < 10) return r;
    sel = $urandom_range(0, 99);
    idx = int'(r.hash) % SLOTS;
    if (sel < 55) begin
      r.op = OP_LOOKUP;
      if ($urandom_range(0, 99) < 70) begin
        r.imp_h = tag_mirror[idx];
        r.mode = mode_mirror[idx];
        case ($urandom_range(0, 9))
          0: r.mode[$urandom_range(0, MODE_W-1)] ^= 1'b1;
          1: r.imp_h[$urandom_range(0, HANDLE_W-1)] ^= 1'b1;
          2: r.imp_h = '0;
          default: ;
        endcase
      end else begin
        r.imp_h = imp_pool[$urandom_range(0, 7)];
      end
    end else if (sel < 90) begin
      r.op = OP_ENTER;
      if ($urandom_range(0, 99) < 3) r.imp_h = '0;
      else if ($urandom_range(0, 1)) r.imp_h = imp_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 1)) r.mode = MODE_W'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 85) r.mod_h = mod_pool[$urandom_range(0, 3)];
    end else if (sel < 97) begin
      r.op = OP_INVAL;
      case ($urandom_range(0, 19))
        0: r.mod_h = '0;
        1: ;
        default: r.mod_h = mod_pool[$urandom_range(0, 3)];
      endcase
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic send_beat(symreq_t r, answer_t typed_want, bit use_typed, bit calm);
    int gap;
    answer_t a;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    op <= r.op;
    slot_hash <= r.hash;
    import_id <= r.imp_h;
    mode_flags <= r.mode;
    module_id <= r.mod_h;
    export_id <= r.exp_h;
    do @(posedge clk); while (req_stall);
    a = cache_step(r);
    answer_q.push_back(use_typed ? typed_want : a);
    n_beats++;
  endtask

  task automatic drain_answers();
    req_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit calm;
    for (int i = 0; i < SLOTS; i++) begin
      tag_mirror[i] = '0;
      mode_mirror[i] = '0;
      mod_mirror[i] = '0;
      exp_mirror[i] = '0;
    end
    for (int i = 0; i < 4; i++) mod_pool[i] = $urandom | 32'h1;
    for (int i = 0; i < 8; i++) imp_pool[i] = $urandom | 32'h1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_beat(dir_rows[i].rq, dir_rows[i].want, dir_rows[i].typed, 1'b0);
    drain_answers();
    calm = 1'b0;
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RAND_BEATS / 2) drain_answers();
      send_beat(pick_request(), '0, 1'b0, calm);
    end
    drain_answers();
    repeat (SLOTS + 8) @(posedge clk);
    $display("Covered %0d beats: %0d lookups (%0d hits), %0d enters, %0d sweeps, %0d unused ops.",
             n_beats, n_lookup, n_hit, n_enter, n_sweep, n_unused);
    if (fail_count == 0) begin
      $display("direct_mapped_symbol_cache_tb OK");
    end else begin
      $display("direct_mapped_symbol_cache_tb NOT OK");
    end
    $finish;
  end

  initial begin
    int hold;
    bit calm;
    calm = 1'b0;
    @(negedge rst);
    forever begin
      if (rsp_seen % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (rsp_seen == 200 || rsp_seen == 1000) hold = 300;
      else hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      rsp_seen++;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (answer_q.size() == 0) begin
        $error("response beat with no request outstanding");
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          fail_count++;
        end
        if (found_module !== want.found_mod) begin
          $error("found_module: expected %h, got %h", want.found_mod, found_module);
          fail_count++;
        end
        if (found_export !== want.found_exp) begin
          $error("found_export: expected %h, got %h", want.found_exp, found_export);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("direct_mapped_symbol_cache_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dmsc_pkg.sv
hw/rtl/dmsc_front.sv
hw/rtl/dmsc_queue.sv
hw/rtl/dmsc_back.sv
hw/rtl/direct_mapped_symbol_cache.sv
tb/direct_mapped_symbol_cache_tb.sv
